// File: design/spd_pkg.sv
package spd_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 24;
    localparam int DIST_BITS   = COORD_BITS + 1;

    // Internal widths, all derived from the coordinate and projection widths.
    localparam int DW     = COORD_BITS + 1;        // coordinate difference
    localparam int PW     = 2 * DW;                // product of two differences
    localparam int SW     = PW + 1;                // sum of two products
    localparam int RW     = SW + 1;                // divider remainder
    localparam int TW     = T_FRAC_BITS + 1;       // projection parameter, 0..1
    localparam int DIV_ST = (T_FRAC_BITS + 1) / 2; // two quotient bits per stage
    localparam int EW     = DW + T_FRAC_BITS + 3;  // offset to nearest point
    localparam int HL     = (EW + 1) / 2;          // low half for split squaring
    localparam int HH     = EW - HL;               // high half
    localparam int SQW    = 2 * EW + 1;            // squared distance
    localparam int XW     = SQW - 2 * T_FRAC_BITS; // squared distance, integer part
    localparam int RB     = (XW + 1) / 2;          // root bits
    localparam int XP     = 2 * RB;                // radicand padded to even width
    localparam int RMW    = RB + 2;                // root remainder
    localparam int SQ_ST  = (RB + 1) / 2;          // two root bits per stage

    localparam int ORI_ST   = 4;
    localparam int PROJ_LAT = 10 + DIV_ST;
    localparam int MIN_LAT  = 2;
    localparam int CORE_LAT = PROJ_LAT + MIN_LAT + SQ_ST;
    localparam int ORI_DLY  = CORE_LAT - ORI_ST;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [TW-1:0]        T_ONE    = TW'(1) << T_FRAC_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DW-1:0]         t_diff;
    typedef logic signed [PW-1:0]         t_prod;
    typedef logic signed [SW-1:0]         t_sum;
    typedef logic [SQW-1:0]               t_sq;
    typedef logic [RB-1:0]                t_root;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef struct packed {
        logic valid;
        logic touch;
    } t_tag;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [TW-1:0] q;
    } t_divs;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [RB-1:0]  root;
        logic [XP-1:0]  x;
    } t_sqs;

    function automatic t_diff sx(t_coord c);
        return {c[COORD_BITS-1], c};
    endfunction

    // One restoring division step: shift the remainder, try the divisor.
    function automatic t_divs div_step(t_divs s, logic [RW-1:0] den);
        t_divs r;
        logic [RW-1:0] sh;
        sh = {s.rem[RW-2:0], 1'b0};
        if (sh >= den) begin
            r.rem = sh - den;
            r.q   = {s.q[TW-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.q   = {s.q[TW-2:0], 1'b0};
        end
        return r;
    endfunction

    // One digit-by-digit square root step, consuming two radicand bits.
    function automatic t_sqs sqrt_step(t_sqs s);
        t_sqs r;
        logic [RMW-1:0] sh;
        logic [RMW-1:0] trial;
        sh    = {s.rem[RMW-3:0], s.x[XP-1 -: 2]};
        trial = {s.root, 2'b01};
        r.x   = {s.x[XP-3:0], 2'b00};
        if (sh >= trial) begin
            r.rem  = sh - trial;
            r.root = {s.root[RB-2:0], 1'b1};
        end else begin
            r.rem  = sh;
            r.root = {s.root[RB-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: design/spd_orient.sv
module spd_orient (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  spd_pkg::t_pt  i_a,
    input  spd_pkg::t_pt  i_b,
    input  spd_pkg::t_pt  i_c,
    input  spd_pkg::t_pt  i_d,
    output spd_pkg::t_tag o_tag
);

    function automatic logic in_box(spd_pkg::t_pt p, spd_pkg::t_pt a, spd_pkg::t_pt b);
        return ((p.x >= a.x) || (p.x >= b.x)) && ((p.x <= a.x) || (p.x <= b.x)) &&
               ((p.y >= a.y) || (p.y >= b.y)) && ((p.y <= a.y) || (p.y <= b.y));
    endfunction

    function automatic logic opposite(spd_pkg::t_sum u, spd_pkg::t_sum v);
        return (u[spd_pkg::SW-1] && (v != '0) && !v[spd_pkg::SW-1]) ||
               (v[spd_pkg::SW-1] && (u != '0) && !u[spd_pkg::SW-1]);
    endfunction

    logic [2:0] r_vld;

    spd_pkg::t_diff r_abx, r_aby, r_acx, r_acy, r_adx, r_ady;
    spd_pkg::t_diff r_cdx, r_cdy, r_cax, r_cay, r_cbx, r_cby;
    logic [3:0]     r_box1, r_box2, r_box3;

    spd_pkg::t_prod r_p [8];
    spd_pkg::t_sum  r_o1, r_o2, r_o3, r_o4;

    spd_pkg::t_tag  r_dly [spd_pkg::ORI_DLY + 1];

    // Stage 1: edge vectors and bounding box tests.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abx  <= spd_pkg::sx(i_b.x) - spd_pkg::sx(i_a.x);
            r_aby  <= spd_pkg::sx(i_b.y) - spd_pkg::sx(i_a.y);
            r_acx  <= spd_pkg::sx(i_c.x) - spd_pkg::sx(i_a.x);
            r_acy  <= spd_pkg::sx(i_c.y) - spd_pkg::sx(i_a.y);
            r_adx  <= spd_pkg::sx(i_d.x) - spd_pkg::sx(i_a.x);
            r_ady  <= spd_pkg::sx(i_d.y) - spd_pkg::sx(i_a.y);
            r_cdx  <= spd_pkg::sx(i_d.x) - spd_pkg::sx(i_c.x);
            r_cdy  <= spd_pkg::sx(i_d.y) - spd_pkg::sx(i_c.y);
            r_cax  <= spd_pkg::sx(i_a.x) - spd_pkg::sx(i_c.x);
            r_cay  <= spd_pkg::sx(i_a.y) - spd_pkg::sx(i_c.y);
            r_cbx  <= spd_pkg::sx(i_b.x) - spd_pkg::sx(i_c.x);
            r_cby  <= spd_pkg::sx(i_b.y) - spd_pkg::sx(i_c.y);
            r_box1 <= {in_box(i_b, i_c, i_d), in_box(i_a, i_c, i_d),
                       in_box(i_d, i_a, i_b), in_box(i_c, i_a, i_b)};
        end
    end

    // Stage 2: cross product terms.  Stage 3: the four orientations.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= r_abx * r_acy;
            r_p[1] <= r_aby * r_acx;
            r_p[2] <= r_abx * r_ady;
            r_p[3] <= r_aby * r_adx;
            r_p[4] <= r_cdx * r_cay;
            r_p[5] <= r_cdy * r_cax;
            r_p[6] <= r_cdx * r_cby;
            r_p[7] <= r_cdy * r_cbx;
            r_box2 <= r_box1;
            r_o1   <= spd_pkg::SW'(r_p[0]) - spd_pkg::SW'(r_p[1]);
            r_o2   <= spd_pkg::SW'(r_p[2]) - spd_pkg::SW'(r_p[3]);
            r_o3   <= spd_pkg::SW'(r_p[4]) - spd_pkg::SW'(r_p[5]);
            r_o4   <= spd_pkg::SW'(r_p[6]) - spd_pkg::SW'(r_p[7]);
            r_box3 <= r_box2;
        end
    end

    // Stage 4 decides touching; the tag then waits for the distance path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int i = 0; i <= spd_pkg::ORI_DLY; i++) begin
                r_dly[i] <= '0;
            end
        end else if (i_en) begin
            r_vld          <= {r_vld[1:0], i_valid};
            r_dly[0].valid <= r_vld[2];
            r_dly[0].touch <= (opposite(r_o1, r_o2) && opposite(r_o3, r_o4)) ||
                              ((r_o1 == '0) && r_box3[0]) ||
                              ((r_o2 == '0) && r_box3[1]) ||
                              ((r_o3 == '0) && r_box3[2]) ||
                              ((r_o4 == '0) && r_box3[3]);
            for (int i = 1; i <= spd_pkg::ORI_DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_tag = r_dly[spd_pkg::ORI_DLY];

endmodule

// File: design/spd_proj.sv
module spd_proj (
    input  logic         i_clk,
    input  logic         i_en,
    input  spd_pkg::t_pt i_p,
    input  spd_pkg::t_pt i_a,
    input  spd_pkg::t_pt i_b,
    output spd_pkg::t_sq o_sq
);

    typedef struct packed {
        spd_pkg::t_diff  vx;
        spd_pkg::t_diff  vy;
        spd_pkg::t_diff  wx;
        spd_pkg::t_diff  wy;
        logic            tone;
        logic [spd_pkg::RW-1:0] den;
    } t_carry;

    spd_pkg::t_diff r_vx, r_vy, r_wx, r_wy;
    spd_pkg::t_diff r2_vx, r2_vy, r2_wx, r2_wy;
    spd_pkg::t_prod r_pvx, r_pvy, r_pwx, r_pwy;
    spd_pkg::t_diff r3_vx, r3_vy, r3_wx, r3_wy;
    spd_pkg::t_sum  r_len2, r_dot;

    t_carry         r_c   [spd_pkg::DIV_ST + 1];
    spd_pkg::t_divs r_div [spd_pkg::DIV_ST + 1];

    logic signed [spd_pkg::EW-1:0] r_ptx, r_pty, r_ex, r_ey;
    spd_pkg::t_diff                r_fwx, r_fwy;
    logic [spd_pkg::EW-1:0]        r_mx, r_my;
    logic [2*spd_pkg::HH-1:0]       r_hhx, r_hhy;
    logic [spd_pkg::HH+spd_pkg::HL-1:0] r_hlx, r_hly;
    logic [2*spd_pkg::HL-1:0]       r_llx, r_lly;
    spd_pkg::t_sq                  r_sqx, r_sqy, r_sq;

    logic [spd_pkg::TW-1:0]        n_t;
    logic signed [spd_pkg::EW-1:0] n_ex, n_ey;

    // Stages 1 to 3: vectors, dot product and squared length.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx   <= spd_pkg::sx(i_b.x) - spd_pkg::sx(i_a.x);
            r_vy   <= spd_pkg::sx(i_b.y) - spd_pkg::sx(i_a.y);
            r_wx   <= spd_pkg::sx(i_p.x) - spd_pkg::sx(i_a.x);
            r_wy   <= spd_pkg::sx(i_p.y) - spd_pkg::sx(i_a.y);
            r_pvx  <= r_vx * r_vx;
            r_pvy  <= r_vy * r_vy;
            r_pwx  <= r_wx * r_vx;
            r_pwy  <= r_wy * r_vy;
            r2_vx  <= r_vx;
            r2_vy  <= r_vy;
            r2_wx  <= r_wx;
            r2_wy  <= r_wy;
            r_len2 <= spd_pkg::SW'(r_pvx) + spd_pkg::SW'(r_pvy);
            r_dot  <= spd_pkg::SW'(r_pwx) + spd_pkg::SW'(r_pwy);
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;
            r3_wx  <= r2_wx;
            r3_wy  <= r2_wy;
        end
    end

    // Stage 4 clamps; the divider only sees dots strictly inside (0, len2).
    // A zero-length segment has a zero dot and so lands on the clamp at one.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0].vx   <= r3_vx;
            r_c[0].vy   <= r3_vy;
            r_c[0].wx   <= r3_wx;
            r_c[0].wy   <= r3_wy;
            r_c[0].tone <= (r_dot >= r_len2);
            r_c[0].den  <= spd_pkg::RW'($unsigned(r_len2));
            r_div[0].q  <= '0;
            if ((r_dot <= 0) || (r_dot >= r_len2)) begin
                r_div[0].rem <= '0;
            end else begin
                r_div[0].rem <= spd_pkg::RW'($unsigned(r_dot));
            end
        end
    end

    for (genvar s = 0; s < spd_pkg::DIV_ST; s++) begin : g_div
        spd_pkg::t_divs n_d;
        always_comb begin
            n_d = r_div[s];
            for (int k = 0; k < 2; k++) begin
                if (2 * s + k < spd_pkg::T_FRAC_BITS) begin
                    n_d = spd_pkg::div_step(n_d, r_c[s].den);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[s+1] <= n_d;
                r_c[s+1]   <= r_c[s];
            end
        end
    end

    always_comb begin
        n_t  = r_c[spd_pkg::DIV_ST].tone ? spd_pkg::T_ONE : r_div[spd_pkg::DIV_ST].q;
        n_ex = (spd_pkg::EW'(r_fwx) <<< spd_pkg::T_FRAC_BITS) - r_ptx;
        n_ey = (spd_pkg::EW'(r_fwy) <<< spd_pkg::T_FRAC_BITS) - r_pty;
    end

    // Nearest point offset, its magnitude, split squaring and the final sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ptx <= $signed({1'b0, n_t}) * r_c[spd_pkg::DIV_ST].vx;
            r_pty <= $signed({1'b0, n_t}) * r_c[spd_pkg::DIV_ST].vy;
            r_fwx <= r_c[spd_pkg::DIV_ST].wx;
            r_fwy <= r_c[spd_pkg::DIV_ST].wy;
            r_ex  <= n_ex;
            r_ey  <= n_ey;
            r_mx  <= r_ex[spd_pkg::EW-1] ? $unsigned(-r_ex) : $unsigned(r_ex);
            r_my  <= r_ey[spd_pkg::EW-1] ? $unsigned(-r_ey) : $unsigned(r_ey);
            r_hhx <= r_mx[spd_pkg::EW-1:spd_pkg::HL] * r_mx[spd_pkg::EW-1:spd_pkg::HL];
            r_hlx <= r_mx[spd_pkg::EW-1:spd_pkg::HL] * r_mx[spd_pkg::HL-1:0];
            r_llx <= r_mx[spd_pkg::HL-1:0] * r_mx[spd_pkg::HL-1:0];
            r_hhy <= r_my[spd_pkg::EW-1:spd_pkg::HL] * r_my[spd_pkg::EW-1:spd_pkg::HL];
            r_hly <= r_my[spd_pkg::EW-1:spd_pkg::HL] * r_my[spd_pkg::HL-1:0];
            r_lly <= r_my[spd_pkg::HL-1:0] * r_my[spd_pkg::HL-1:0];
            r_sqx <= (spd_pkg::SQW'(r_hhx) << (2 * spd_pkg::HL)) +
                     (spd_pkg::SQW'(r_hlx) << (spd_pkg::HL + 1)) + spd_pkg::SQW'(r_llx);
            r_sqy <= (spd_pkg::SQW'(r_hhy) << (2 * spd_pkg::HL)) +
                     (spd_pkg::SQW'(r_hly) << (spd_pkg::HL + 1)) + spd_pkg::SQW'(r_lly);
            r_sq  <= r_sqx + r_sqy;
        end
    end

    assign o_sq = r_sq;

endmodule

// File: design/spd_sqrt.sv
module spd_sqrt (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [spd_pkg::XW-1:0] i_x,
    output spd_pkg::t_root        o_root
);

    spd_pkg::t_sqs r_st [spd_pkg::SQ_ST];

    for (genvar s = 0; s < spd_pkg::SQ_ST; s++) begin : g_st
        spd_pkg::t_sqs n_s;
        always_comb begin
            if (s == 0) begin
                n_s.rem  = '0;
                n_s.root = '0;
                n_s.x    = spd_pkg::XP'(i_x);
            end else begin
                n_s = r_st[(s == 0) ? 0 : s - 1];
            end
            for (int k = 0; k < 2; k++) begin
                if (2 * s + k < spd_pkg::RB) begin
                    n_s = spd_pkg::sqrt_step(n_s);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_s;
            end
        end
    end

    assign o_root = r_st[spd_pkg::SQ_ST-1].root;

endmodule

// File: design/segment_pair_distance.sv
// Throughput: one segment pair per cycle while no result is stalled;
// every stage is pipelined, with the 24-step projection divider and
// the square root spread two steps per stage. The whole pipeline
// advances together and holds while a result is stalled.
// Reset (synchronous, active low) clears the valid bits; data is not reset.
module segment_pair_distance (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_first_start_x,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_first_start_y,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_first_end_x,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_first_end_y,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_second_start_x,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_second_start_y,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_second_end_x,
    input  logic signed [spd_pkg::COORD_BITS-1:0] i_second_end_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [spd_pkg::DIST_BITS-1:0]     o_distance,
    output logic                              o_touching
);

    logic          en;
    logic          r_in_valid;
    spd_pkg::t_pt  r_a, r_b, r_c, r_d;
    spd_pkg::t_tag tag;
    spd_pkg::t_sq  sq [4];
    spd_pkg::t_sq  r_min01, r_min23, r_best;
    spd_pkg::t_root root;

    logic                          r_out_valid;
    logic [spd_pkg::DIST_BITS-1:0] r_dist;
    logic                          r_touch;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= '{x: i_first_start_x, y: i_first_start_y};
            r_b <= '{x: i_first_end_x, y: i_first_end_y};
            r_c <= '{x: i_second_start_x, y: i_second_start_y};
            r_d <= '{x: i_second_end_x, y: i_second_end_y};
        end
    end

    spd_orient u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .o_tag   (tag)
    );

    spd_proj u_proj_a (.i_clk(i_clk), .i_en(en), .i_p(r_a), .i_a(r_c), .i_b(r_d), .o_sq(sq[0]));
    spd_proj u_proj_b (.i_clk(i_clk), .i_en(en), .i_p(r_b), .i_a(r_c), .i_b(r_d), .o_sq(sq[1]));
    spd_proj u_proj_c (.i_clk(i_clk), .i_en(en), .i_p(r_c), .i_a(r_a), .i_b(r_b), .o_sq(sq[2]));
    spd_proj u_proj_d (.i_clk(i_clk), .i_en(en), .i_p(r_d), .i_a(r_a), .i_b(r_b), .o_sq(sq[3]));

    // Two-level minimum over the four squared distances.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_min01 <= (sq[1] <= sq[0]) ? sq[1] : sq[0];
            r_min23 <= (sq[3] <= sq[2]) ? sq[3] : sq[2];
            r_best  <= (r_min23 <= r_min01) ? r_min23 : r_min01;
        end
    end

    // Dropping the fractional bits of the square before the root gives the
    // same floored result as shifting the root afterwards.
    spd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_best[spd_pkg::SQW-1:2*spd_pkg::T_FRAC_BITS]),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_touch <= tag.touch;
            if (tag.touch) begin
                r_dist <= '0;
            end else if (root > spd_pkg::RB'(spd_pkg::DIST_MAX)) begin
                r_dist <= spd_pkg::DIST_MAX;
            end else begin
                r_dist <= root[spd_pkg::DIST_BITS-1:0];
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_dist;
    assign o_touching = r_touch;

endmodule

// File: design/spd_checker.sv
module spd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [spd_pkg::DIST_BITS-1:0] o_distance,
    input logic                          o_touching
);

    // A touching pair always reports zero distance.
    a_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_touching) |-> (o_distance == '0))
        else $error("touching result with nonzero distance");

    // The input side is held back only by a stalled result.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without a stalled result");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_distance) && $stable(o_touching)))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind segment_pair_distance spd_checker u_spd_checker (.*);
